### rtl/iir_direct_form_two_filter_defines.svh
// ---------------------------------------------------------------------------
// iir_direct_form_two_filter_defines
// assertion macros shared by the filter modules
// ---------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IIR2_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iir2 same-cycle check failed");

// next-cycle implication, checked out of reset
`define IIR2_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iir2 next-cycle check failed");

`endif

### rtl/iir2_pkg.sv
// ---------------------------------------------------------------------------
// iir2_pkg
// types, constants, control program and rounding for the iir filter
// ---------------------------------------------------------------------------
package iir2_pkg;

  // data formats
  localparam int COEF_W   = 18;
  localparam int SAMP_W   = 16;
  localparam int PROD_W   = COEF_W + SAMP_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int FRAC     = 14;
  localparam int ROUND_HALF = 8192;

  // configuration registers
  localparam int NUM_COEF = 6;
  localparam int CIDX_W   = 3;
  typedef logic [CIDX_W-1:0] coef_sel_t;
  localparam coef_sel_t COEF_REC0 = 3'd0;
  localparam coef_sel_t COEF_REC1 = 3'd1;
  localparam coef_sel_t COEF_REC2 = 3'd2;
  localparam coef_sel_t COEF_OUT0 = 3'd3;
  localparam coef_sel_t COEF_OUT1 = 3'd4;
  localparam coef_sel_t COEF_OUT2 = 3'd5;
  localparam logic signed [COEF_W-1:0] COEF_UNITY = 18'sd16384;

  // program counter
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_RND_W = 3'd3;
  localparam pc_t PC_OUT   = 3'd7;

  // control word fields
  typedef enum logic [1:0] {
    OP_MAC   = 2'd0,
    OP_RND_W = 2'd1,
    OP_OUT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    OPD_X = 2'd0,
    OPD_W = 2'd1,
    OPD_D = 2'd2
  } opd_t;

  typedef enum logic {
    JMP_NONE      = 1'b0,
    JMP_LOW_ORDER = 1'b1
  } jmp_t;

  localparam int DSEL_W = 1;
  typedef logic [DSEL_W-1:0] dsel_t;
  localparam dsel_t DSEL_D1 = 1'b0;
  localparam dsel_t DSEL_D2 = 1'b1;

  typedef struct packed {
    op_t       op;
    logic      clr;
    coef_sel_t coef;
    opd_t      opd;
    dsel_t     dsel;
    jmp_t      jmp;
    pc_t       target;
  } ctrl_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic       exec;
    ctrl_word_t word;
  } ctrl_t;

  // control program: recursive sum, round w, output sum, round y
  function automatic ctrl_word_t prog_rom(input pc_t pc);
    ctrl_word_t cw;
    case (pc)
      3'd0: cw = '{OP_MAC,   1'b1, COEF_REC0, OPD_X, DSEL_D1, JMP_NONE,      PC_RND_W};
      3'd1: cw = '{OP_MAC,   1'b0, COEF_REC1, OPD_D, DSEL_D1, JMP_LOW_ORDER, PC_RND_W};
      3'd2: cw = '{OP_MAC,   1'b0, COEF_REC2, OPD_D, DSEL_D2, JMP_NONE,      PC_RND_W};
      3'd3: cw = '{OP_RND_W, 1'b0, COEF_REC0, OPD_X, DSEL_D1, JMP_NONE,      PC_OUT};
      3'd4: cw = '{OP_MAC,   1'b1, COEF_OUT0, OPD_W, DSEL_D1, JMP_NONE,      PC_OUT};
      3'd5: cw = '{OP_MAC,   1'b0, COEF_OUT1, OPD_D, DSEL_D1, JMP_LOW_ORDER, PC_OUT};
      3'd6: cw = '{OP_MAC,   1'b0, COEF_OUT2, OPD_D, DSEL_D2, JMP_NONE,      PC_OUT};
      3'd7: cw = '{OP_OUT,   1'b0, COEF_OUT0, OPD_X, DSEL_D1, JMP_NONE,      PC_OUT};
      default: cw = '{OP_OUT, 1'b0, COEF_OUT0, OPD_X, DSEL_D1, JMP_NONE,     PC_OUT};
    endcase
    return cw;
  endfunction

  // round half up to q1.15 and saturate
  function automatic logic signed [SAMP_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic [ACC_W-FRAC-1:0]   q;
    logic signed [SAMP_W-1:0] res;
    biased = acc + ACC_W'(ROUND_HALF);
    q = biased[ACC_W-1:FRAC];
    if ((&q[ACC_W-FRAC-1:SAMP_W-1]) || !(|q[ACC_W-FRAC-1:SAMP_W-1])) begin
      res = q[SAMP_W-1:0];
    end else if (q[ACC_W-FRAC-1]) begin
      res = {1'b1, {(SAMP_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMP_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### rtl/iir2_sample_if.sv
// ---------------------------------------------------------------------------
// iir2_sample_if
// valid/ready channel carrying one q1.15 sample per beat
// ---------------------------------------------------------------------------
interface iir2_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [iir2_pkg::SAMP_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/iir_direct_form_two_filter.sv
// ---------------------------------------------------------------------------
// iir_direct_form_two_filter
// direct form ii iir filter on a microcoded shared multiply-accumulate
// ---------------------------------------------------------------------------
//  channel  | dir | signals                       | beat
//  ---------+-----+-------------------------------+----------------------------
//  in_chan  | in  | valid, ready, sample[15:0]    | one q1.15 input sample
//  out_chan | out | valid, ready, sample[15:0]    | one rounded q1.15 result
//  cfg      | in  | cfg_we, cfg_index, cfg_data   | one coefficient write
//
//  each sample runs one step per product on the shared 18x16
//  multiply-accumulate, plus one rounding step for each section.
//  the next sample is taken in the cycle in which the output step completes.
//  reset sets both section gains to 1.0, the other weights and the delay
//  line to zero; there is no clearing pass.
//  the output step waits while a result is still held in the output register.
// ---------------------------------------------------------------------------
module iir_direct_form_two_filter #(
  parameter int ORDER = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [iir2_pkg::CIDX_W-1:0] cfg_index,
  input  logic [iir2_pkg::COEF_W-1:0] cfg_data,
  iir2_sample_if.sink                 in_chan,
  iir2_sample_if.source               out_chan
);

  logic            in_rdy;
  logic            in_fire;
  logic            out_free;
  iir2_pkg::ctrl_t ctrl;

  assign in_chan.ready = in_rdy;
  assign in_fire       = in_chan.valid && in_rdy;

  // program sequencer
  iir2_seq #(
    .ORDER (ORDER)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .out_free (out_free),
    .in_rdy   (in_rdy),
    .ctrl     (ctrl)
  );

  // datapath
  iir2_dp #(
    .ORDER (ORDER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .in_sample  (in_chan.sample),
    .ctrl       (ctrl),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_sample (out_chan.sample),
    .out_free   (out_free)
  );

endmodule

### rtl/iir2_seq.sv
// ---------------------------------------------------------------------------
// iir2_seq
// step counter and control store that run the filter program
// ---------------------------------------------------------------------------
`include "iir_direct_form_two_filter_defines.svh"

module iir2_seq #(
  parameter int ORDER = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_free,
  output logic            in_rdy,
  output iir2_pkg::ctrl_t ctrl
);

  logic                busy_r, busy_nxt;
  iir2_pkg::pc_t       pc_r, pc_nxt;
  iir2_pkg::ctrl_word_t step;
  logic                stall;
  logic                done;
  logic                jump;

  // decode current step
  always_comb begin
    step  = iir2_pkg::prog_rom(pc_r);
    stall = busy_r && (step.op == iir2_pkg::OP_OUT) && !out_free;
    done  = busy_r && (step.op == iir2_pkg::OP_OUT) && out_free;
    jump  = (step.jmp == iir2_pkg::JMP_LOW_ORDER) && (ORDER < 2);
    in_rdy = !busy_r || done;
    ctrl.exec = busy_r && !stall;
    ctrl.word = step;
  end

  // next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !stall) begin
      pc_nxt = jump ? step.target : pc_r + iir2_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // a new beat always restarts the program at its first step
  `IIR2_ASSERT_NXT(a_start_pc0, clk, rst_n, start, busy_r && (pc_r == '0))
  // a stalled output step keeps its place
  `IIR2_ASSERT_NXT(a_stall_hold, clk, rst_n, stall, $stable(pc_r) && busy_r)

endmodule

### rtl/iir2_dp.sv
// ---------------------------------------------------------------------------
// iir2_dp
// coefficient registers, delay line, shared mac and output register
// ---------------------------------------------------------------------------
`include "iir_direct_form_two_filter_defines.svh"

module iir2_dp #(
  parameter int ORDER = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [iir2_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [iir2_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 in_fire,
  input  logic signed [iir2_pkg::SAMP_W-1:0]   in_sample,
  input  iir2_pkg::ctrl_t                      ctrl,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [iir2_pkg::SAMP_W-1:0]   out_sample,
  output logic                                 out_free
);

  logic signed [iir2_pkg::COEF_W-1:0] coef_r [iir2_pkg::NUM_COEF];
  logic signed [iir2_pkg::SAMP_W-1:0] dly_r  [ORDER];
  logic signed [iir2_pkg::SAMP_W-1:0] x_r;
  logic signed [iir2_pkg::SAMP_W-1:0] w_r;
  logic signed [iir2_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [iir2_pkg::SAMP_W-1:0] out_sample_r;
  logic                               out_valid_r;
  logic signed [iir2_pkg::SAMP_W-1:0] opd;
  logic signed [iir2_pkg::COEF_W-1:0] coef;
  logic signed [iir2_pkg::PROD_W-1:0] prod;
  logic signed [iir2_pkg::SAMP_W-1:0] rnd;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < iir2_pkg::NUM_COEF; k++) begin
        coef_r[k] <= ((k == int'(iir2_pkg::COEF_REC0)) || (k == int'(iir2_pkg::COEF_OUT0)))
                     ? iir2_pkg::COEF_UNITY : '0;
      end
    end else if (cfg_we && (cfg_index < iir2_pkg::CIDX_W'(iir2_pkg::NUM_COEF))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // operand and coefficient select, one multiply
  always_comb begin
    opd = x_r;
    case (ctrl.word.opd)
      iir2_pkg::OPD_X: opd = x_r;
      iir2_pkg::OPD_W: opd = w_r;
      iir2_pkg::OPD_D: begin
        for (int k = 0; k < ORDER; k++) begin
          if (int'(ctrl.word.dsel) == k) opd = dly_r[k];
        end
      end
      default: opd = x_r;
    endcase
    coef = coef_r[ctrl.word.coef];
    prod = coef * opd;
    acc_nxt = (ctrl.word.clr ? '0 : acc_r) + iir2_pkg::ACC_W'(prod);
    rnd = iir2_pkg::rnd_sat(acc_r);
  end

  // sample latch, accumulator, w register
  always_ff @(posedge clk) begin
    if (in_fire) x_r <= in_sample;
    if (ctrl.exec && (ctrl.word.op == iir2_pkg::OP_MAC)) acc_r <= acc_nxt;
    if (ctrl.exec && (ctrl.word.op == iir2_pkg::OP_RND_W)) w_r <= rnd;
    if (ctrl.exec && (ctrl.word.op == iir2_pkg::OP_OUT)) out_sample_r <= rnd;
  end

  // delay line shifts once per sample, w enters as d_1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) dly_r[k] <= '0;
    end else if (ctrl.exec && (ctrl.word.op == iir2_pkg::OP_OUT)) begin
      for (int k = ORDER - 1; k > 0; k--) dly_r[k] <= dly_r[k-1];
      dly_r[0] <= w_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.exec && (ctrl.word.op == iir2_pkg::OP_OUT)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // the output step only runs into a free output register
  `IIR2_ASSERT_IMP(a_out_free, clk, rst_n,
    ctrl.exec && (ctrl.word.op == iir2_pkg::OP_OUT), out_free)
  // a finished output step shows a beat next cycle
  `IIR2_ASSERT_NXT(a_out_valid, clk, rst_n,
    ctrl.exec && (ctrl.word.op == iir2_pkg::OP_OUT), out_valid_r)

endmodule
